// File: src/ostt_pkg.sv
package ostt_pkg;

	// Table size that the top level uses unless told otherwise.
	localparam int NUM_TIMERS_DEF = 8;

	// Fixed field widths.
	localparam int KIND_W   = 3;
	localparam int ID_W     = 3;
	localparam int PERIOD_W = 16;
	localparam int COUNT_W  = 17;
	localparam int TS_W     = 2;

	// Item kinds.
	localparam logic [KIND_W-1:0] KIND_CREATE  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_SET     = 3'd1;
	localparam logic [KIND_W-1:0] KIND_QUERY   = 3'd2;
	localparam logic [KIND_W-1:0] KIND_DELETE  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_RESTART = 3'd4;
	localparam logic [KIND_W-1:0] KIND_TICK    = 3'd5;

	// Query answers.
	localparam logic [TS_W-1:0] TS_STOPPED = 2'd0;
	localparam logic [TS_W-1:0] TS_RUNNING = 2'd1;
	localparam logic [TS_W-1:0] TS_INVALID = 2'd2;

	// Response status codes.
	localparam logic ST_OK   = 1'b0;
	localparam logic ST_FAIL = 1'b1;

	// Result kinds.
	localparam logic RES_RESPONSE = 1'b0;
	localparam logic RES_EXPIRY   = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic cmd_accept;   // a command item is taken this cycle
		logic tick_accept;  // a tick item is taken this cycle
		logic walk_step;    // read the walk entry and advance the walk index
		logic eval_en;      // the entry read last cycle is evaluated
		logic flush;        // the held expiry event goes out as the final one
	} ctl_cmd_t;

endpackage

// File: src/ostt_ctrl.sv
module ostt_ctrl
	import ostt_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [KIND_W-1:0]    kind,
	input  logic                 walk_at_end,
	output logic                 busy,
	output ctl_cmd_t             cmd
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_WALK  = 4'b0010,
		S_DRAIN = 4'b0100,
		S_FLUSH = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   rd_valid_s1;
	logic   accept;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	// Decode the accepted item and the walk phase into datapath commands.
	always_comb begin
		cmd             = '0;
		cmd.cmd_accept  = accept && (kind <= KIND_RESTART);
		cmd.tick_accept = accept && (kind == KIND_TICK);
		cmd.walk_step   = (state_q == S_WALK);
		cmd.eval_en     = rd_valid_s1;
		cmd.flush       = (state_q == S_FLUSH);
	end

	// Next state: a tick walks the table, lets the last read settle, then flushes.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd.tick_accept) state_d = S_WALK;
			end
			S_WALK: begin
				if (walk_at_end) state_d = S_DRAIN;
			end
			S_DRAIN: begin
				state_d = S_FLUSH;
			end
			S_FLUSH: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register and the read-valid flag of the walk pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rd_valid_s1 <= 1'b0;
		end else begin
			state_q     <= state_d;
			rd_valid_s1 <= (state_q == S_WALK);
		end
	end

endmodule

// File: src/ostt_dp.sv
module ostt_dp
	import ostt_pkg::*;
#(
	parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ctl_cmd_t             cmd,
	input  logic [KIND_W-1:0]    kind,
	input  logic [ID_W-1:0]      timer_id,
	input  logic [PERIOD_W-1:0]  period,
	input  logic                 new_state,
	input  logic                 handler_present,
	output logic                 walk_at_end,
	output logic                 result_valid,
	output logic                 event_res,
	output logic [ID_W-1:0]      which_timer,
	output logic                 status,
	output logic [TS_W-1:0]      timer_state,
	output logic                 last
);

	localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// Per-timer flags live in flip-flops; counts and periods in memories.
	logic [NUM_TIMERS-1:0] allocated_q;
	logic [NUM_TIMERS-1:0] running_q;
	logic [COUNT_W-1:0]    cnt_mem [NUM_TIMERS];
	logic [PERIOD_W-1:0]   per_mem [NUM_TIMERS];

	logic [IDX_W-1:0]    walk_q;
	logic [IDX_W-1:0]    idx_s1;
	logic [COUNT_W-1:0]  cnt_s1;
	logic [PERIOD_W-1:0] per_s1;

	logic                pend_q;
	logic [IDX_W-1:0]    pend_id_q;

	logic                id_valid;
	logic [IDX_W-1:0]    id_ix;
	logic                id_alloc;
	logic                rsp_status;
	logic [TS_W-1:0]     rsp_ts;

	logic                active;
	logic [COUNT_W-1:0]  cnt_next;
	logic                expire;

	logic                cnt_we;
	logic [IDX_W-1:0]    cnt_wa;
	logic [COUNT_W-1:0]  cnt_wd;
	logic                per_we;

	// Address decode of the command item.
	assign id_valid = (int'(timer_id) < NUM_TIMERS);
	assign id_ix    = IDX_W'(timer_id);
	assign id_alloc = id_valid && allocated_q[id_ix];

	// Response fields of a command.
	always_comb begin
		rsp_status = id_alloc ? ST_OK : ST_FAIL;
		rsp_ts     = TS_STOPPED;
		case (kind)
			KIND_CREATE: begin
				rsp_status = id_valid ? ST_OK : ST_FAIL;
			end
			KIND_QUERY: begin
				if (id_alloc) begin
					rsp_ts = running_q[id_ix] ? TS_RUNNING : TS_STOPPED;
				end else begin
					rsp_ts = TS_INVALID;
				end
			end
			default: begin
				rsp_ts = TS_STOPPED;
			end
		endcase
	end

	// Evaluation of the entry read in the previous cycle.
	assign active   = allocated_q[idx_s1] && running_q[idx_s1];
	assign cnt_next = (cnt_s1 == COUNT_MAX) ? cnt_s1 : cnt_s1 + 1'b1;
	assign expire   = cmd.eval_en && active && (cnt_next >= {1'b0, per_s1});
	assign walk_at_end = (walk_q == IDX_W'(NUM_TIMERS - 1));

	// Write port selection of the count and period memories.
	always_comb begin
		cnt_we = 1'b0;
		cnt_wa = id_ix;
		cnt_wd = '0;
		per_we = 1'b0;
		if (cmd.cmd_accept) begin
			case (kind)
				KIND_CREATE: begin
					cnt_we = id_valid;
					per_we = id_valid;
				end
				KIND_DELETE, KIND_RESTART: begin
					cnt_we = id_alloc;
				end
				default: begin
					cnt_we = 1'b0;
				end
			endcase
		end else if (cmd.eval_en && active) begin
			cnt_we = 1'b1;
			cnt_wa = idx_s1;
			cnt_wd = cnt_next;
		end
	end

	// Count and period memories with a registered read at the walk index.
	always_ff @(posedge clk) begin
		if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
		if (per_we) per_mem[id_ix] <= period;
		cnt_s1 <= cnt_mem[walk_q];
		per_s1 <= per_mem[walk_q];
		idx_s1 <= walk_q;
	end

	// Allocation and run flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			allocated_q <= '0;
			running_q   <= '0;
		end else if (cmd.cmd_accept) begin
			case (kind)
				KIND_CREATE: begin
					if (id_valid) begin
						running_q[id_ix]   <= new_state;
						allocated_q[id_ix] <= handler_present;
					end
				end
				KIND_SET, KIND_RESTART: begin
					if (id_alloc) running_q[id_ix] <= new_state;
				end
				KIND_DELETE: begin
					if (id_alloc) begin
						running_q[id_ix]   <= 1'b0;
						allocated_q[id_ix] <= 1'b0;
					end
				end
				default: begin
					running_q <= running_q;
				end
			endcase
		end else if (expire) begin
			running_q[idx_s1] <= 1'b0;
		end
	end

	// Walk index over the table.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_q <= '0;
		end else if (cmd.tick_accept) begin
			walk_q <= '0;
		end else if (cmd.walk_step && !walk_at_end) begin
			walk_q <= walk_q + 1'b1;
		end
	end

	// One expiry is held back until it is known whether another follows.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else if (cmd.tick_accept || cmd.flush) begin
			pend_q <= 1'b0;
		end else if (expire) begin
			pend_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (expire) pend_id_q <= idx_s1;
	end

	// Result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= cmd.cmd_accept || (pend_q && (expire || cmd.flush));
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (cmd.cmd_accept) begin
			event_res   <= RES_RESPONSE;
			which_timer <= timer_id;
			status      <= rsp_status;
			timer_state <= rsp_ts;
			last        <= 1'b1;
		end else if (pend_q && (expire || cmd.flush)) begin
			event_res   <= RES_EXPIRY;
			which_timer <= ID_W'(pend_id_q);
			status      <= ST_OK;
			timer_state <= TS_STOPPED;
			last        <= cmd.flush;
		end
	end

endmodule

// File: src/one_shot_timer_table_unit.sv
// Table of one-shot tick timers. A command item (create, set run state, query,
// delete, restart) is taken while busy is low, and its single response appears
// on the result ports in the next cycle, so commands can be issued every cycle.
// A tick item raises busy: the count and period memories have one read port,
// so the tick walks the table one timer per cycle, followed by a drain state
// that evaluates the last timer and a flush state that sends the final expiry
// event. Expiry events come out in timer order, one per cycle at most, the final
// one marked by last; a tick with no expiry produces no result. Each result is
// shown for exactly one cycle under result_valid and cannot be held off, so the
// receiver must take it then.
module one_shot_timer_table_unit
	import ostt_pkg::*;
#(
	parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [KIND_W-1:0]    kind,
	input  logic [ID_W-1:0]      timer_id,
	input  logic [PERIOD_W-1:0]  period,
	input  logic                 new_state,
	input  logic                 handler_present,
	output logic                 result_valid,
	output logic                 event_res,
	output logic [ID_W-1:0]      which_timer,
	output logic                 status,
	output logic [TS_W-1:0]      timer_state,
	output logic                 last
);

	ctl_cmd_t cmd;
	logic     walk_at_end;

	// Sequencer for item acceptance and the tick walk.
	ostt_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.kind        (kind),
		.walk_at_end (walk_at_end),
		.busy        (busy),
		.cmd         (cmd)
	);

	// Timer storage, evaluation and result registers.
	ostt_dp #(
		.NUM_TIMERS (NUM_TIMERS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.kind            (kind),
		.timer_id        (timer_id),
		.period          (period),
		.new_state       (new_state),
		.handler_present (handler_present),
		.walk_at_end     (walk_at_end),
		.result_valid    (result_valid),
		.event_res       (event_res),
		.which_timer     (which_timer),
		.status          (status),
		.timer_state     (timer_state),
		.last            (last)
	);

endmodule

// File: src/ostt_checker.sv
module ostt_checker
	import ostt_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 start,
	input logic                 busy,
	input logic [KIND_W-1:0]    kind,
	input logic                 result_valid,
	input logic                 event_res,
	input logic                 status,
	input logic [TS_W-1:0]      timer_state,
	input logic                 last
);

	// A tick item keeps the block busy in the following cycle.
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && kind == KIND_TICK) |=> busy)
		else $error("tick item did not make the block busy");

	// A command item answers with one final response in the next cycle.
	a_cmd_resp: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && kind <= KIND_RESTART) |=>
		(result_valid && event_res == RES_RESPONSE && last))
		else $error("command item gave no final response in the next cycle");

	// Expiry events carry success and no query answer.
	a_event_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && event_res == RES_EXPIRY) |->
		(status == ST_OK && timer_state == TS_STOPPED))
		else $error("expiry event with status or query answer set");

	// An invalid query answer always comes with a failure status.
	a_invalid_fail: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && timer_state == TS_INVALID) |-> (status == ST_FAIL))
		else $error("invalid query answer without failure status");

	// Within a tick, only the event seen once busy has dropped is the final one.
	a_event_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && event_res == RES_EXPIRY) |-> (last == !busy))
		else $error("expiry event last mark disagrees with busy");

endmodule

bind one_shot_timer_table_unit ostt_checker u_ostt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.kind         (kind),
	.result_valid (result_valid),
	.event_res    (event_res),
	.status       (status),
	.timer_state  (timer_state),
	.last         (last)
);
